// ===== hdl/gbpp_pkg.sv =====
// Shared types and constants for the ghost burst packet parser.
// Used by the result queue, the top level and the checker.
package gbpp_pkg;

	localparam int SCAN_WINDOW_DEF  = 16;
	localparam int HEADER_BYTES_DEF = 18;
	localparam int RECORD_BYTES_DEF = 24;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [7:0] MAGIC_0     = 8'h4F;
	localparam logic [7:0] MAGIC_1     = 8'h53;
	localparam logic [7:0] MAGIC_2     = 8'h47;
	localparam logic [7:0] MAGIC_3     = 8'h42;
	localparam logic [7:0] VERSION_ONE = 8'h01;

	// header byte offsets relative to the first magic byte
	localparam int VERSION_REL = 4;
	localparam int COUNT_REL   = 5;
	localparam int TIME_FIRST  = 6;
	localparam int TIME_BYTES  = 8;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_MAGIC    = 2'd1,
		ST_BAD_VERSION = 2'd2,
		ST_TOO_SHORT   = 2'd3
	} status_t;

	typedef enum logic {
		KIND_RECORD = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		PH_SCAN = 4'b0001,
		PH_HEAD = 4'b0010,
		PH_REC  = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	typedef struct packed {
		kind_t       item_kind;
		status_t     status;
		logic [63:0] server_time;
		logic [15:0] entity_id;
		logic [7:0]  record_flags;
		logic [7:0]  team_id;
		logic [31:0] pos_x_bits;
		logic [31:0] pos_y_bits;
		logic [31:0] pos_z_bits;
		logic [31:0] yaw_bits;
		logic [7:0]  damage;
		logic [7:0]  anim_num;
	} result_t;

	// results raised by one byte: a completed record, then the packet status
	typedef struct packed {
		logic rec;
		logic stat;
	} push_t;

endpackage

// ===== hdl/gbpp_ifs.sv =====
// Valid/ready channel interfaces: packet bytes in, parse results out.
// Payload field widths follow gbpp_pkg.
interface gbpp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [15:0] packet_length;
	logic        last_byte;

	modport source (output valid, output data_byte, output packet_length, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input packet_length, input last_byte,
		output ready);
endinterface

interface gbpp_out_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic [1:0]  status;
	logic [63:0] server_time;
	logic [15:0] entity_id;
	logic [7:0]  record_flags;
	logic [7:0]  team_id;
	logic [31:0] pos_x_bits;
	logic [31:0] pos_y_bits;
	logic [31:0] pos_z_bits;
	logic [31:0] yaw_bits;
	logic [7:0]  damage;
	logic [7:0]  anim_num;

	modport source (output valid, output item_kind, output status, output server_time,
		output entity_id, output record_flags, output team_id, output pos_x_bits,
		output pos_y_bits, output pos_z_bits, output yaw_bits, output damage,
		output anim_num, input ready);
	modport sink (input valid, input item_kind, input status, input server_time,
		input entity_id, input record_flags, input team_id, input pos_x_bits,
		input pos_y_bits, input pos_z_bits, input yaw_bits, input damage,
		input anim_num, output ready);
endinterface

// ===== hdl/gbpp_fifo.sv =====
// Result queue: takes up to two results per cycle, presents one per transaction.
// Depends on gbpp_pkg and gbpp_ifs.
module gbpp_fifo #(
	parameter int DEPTH = gbpp_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gbpp_pkg::push_t   push,
	input  gbpp_pkg::result_t rec_res,
	input  gbpp_pkg::result_t stat_res,
	output logic              room,
	gbpp_out_if.source        res_out
);
	import gbpp_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	result_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	result_t          head;

	// room for a record and a status together
	assign room = cnt_q <= CNT_W'(DEPTH - 2);
	assign pop  = res_out.valid && res_out.ready;
	assign head = mem_q[rd_q];

	assign res_out.valid        = cnt_q != '0;
	assign res_out.item_kind    = head.item_kind;
	assign res_out.status       = head.status;
	assign res_out.server_time  = head.server_time;
	assign res_out.entity_id    = head.entity_id;
	assign res_out.record_flags = head.record_flags;
	assign res_out.team_id      = head.team_id;
	assign res_out.pos_x_bits   = head.pos_x_bits;
	assign res_out.pos_y_bits   = head.pos_y_bits;
	assign res_out.pos_z_bits   = head.pos_z_bits;
	assign res_out.yaw_bits     = head.yaw_bits;
	assign res_out.damage       = head.damage;
	assign res_out.anim_num     = head.anim_num;

	always_ff @(posedge clk) begin
		if (push.rec) begin
			mem_q[wr_q] <= rec_res;
		end
		if (push.stat) begin
			mem_q[wr_q + PTR_W'(push.rec)] <= stat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.rec) + PTR_W'(push.stat);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push.rec) + CNT_W'(push.stat) - CNT_W'(pop);
		end
	end

endmodule

// ===== hdl/ghost_burst_packet_parser.sv =====
// Ghost burst packet parser top level: byte register, parse state, result queue.
// Depends on gbpp_pkg, gbpp_ifs and gbpp_fifo.
//
// Usage
//   pkt_in carries one packet byte per transaction, with the packet length
//   repeated on every byte and last_byte set on the final one. res_out carries
//   record results (item_kind 0) and one status result per packet (item_kind 1).
//   A byte that completes a record and ends the packet yields two results,
//   record first.
// Timing
//   One byte per cycle sustained while the queue has room. A byte's result
//   passes the byte register, then the result queue, before it is presented.
//   The byte register feeds the parse logic; results land in a four-entry
//   queue, and a byte is parsed only while the queue has room for two results.
// Reset and stalls
//   arst_n clears the byte register, the parse state and the queue; the block
//   starts scanning for the magic word of a new packet. If res_out stalls, the
//   queue fills and pkt_in.ready drops once the byte register is held; no
//   result is lost or repeated.
module ghost_burst_packet_parser #(
	parameter int SCAN_WINDOW  = gbpp_pkg::SCAN_WINDOW_DEF,
	parameter int HEADER_BYTES = gbpp_pkg::HEADER_BYTES_DEF,
	parameter int RECORD_BYTES = gbpp_pkg::RECORD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gbpp_in_if.sink    pkt_in,
	gbpp_out_if.source res_out
);
	import gbpp_pkg::*;

	localparam int OFF_W = (SCAN_WINDOW > 1) ? $clog2(SCAN_WINDOW) : 1;
	localparam int IDX_W = $clog2(RECORD_BYTES);

	// input byte register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [15:0] len_s1;
	logic        last_s1;

	// packet parse state
	logic [15:0]      pos_q;
	logic [23:0]      recent_q;
	phase_t           phase_q;
	logic [OFF_W-1:0] off_q;
	logic [7:0]       left_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       rbuf_q [RECORD_BYTES];
	logic [63:0]      time_q;
	status_t          err_q;

	phase_t           phase_d;
	logic [OFF_W-1:0] off_d;
	logic [7:0]       left_d;
	logic [IDX_W-1:0] idx_d;
	logic [63:0]      time_d;
	status_t          err_d;

	logic        room;
	logic        fire;
	logic        magic_hit;
	logic [15:0] rel;
	logic [16:0] need;
	logic        rec_done;
	logic [7:0]  rview [22];
	push_t       push;
	result_t     rec_res;
	result_t     stat_res;

	assign fire         = valid_s1 && room;
	assign pkt_in.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt_in.ready) begin
			valid_s1 <= pkt_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_in.valid && pkt_in.ready) begin
			byte_s1 <= pkt_in.data_byte;
			len_s1  <= pkt_in.packet_length;
			last_s1 <= pkt_in.last_byte;
		end
	end

	// Magic ends on this byte: start offset pos-3 must lie in the scan window and
	// leave a full header inside the packet (pos + 1 + header <= length).
	assign magic_hit = (pos_q >= 16'd3) && (pos_q < 16'(SCAN_WINDOW + 3))
		&& ({1'b0, pos_q} + 17'(1 + HEADER_BYTES) <= {1'b0, len_s1})
		&& (recent_q == {MAGIC_0, MAGIC_1, MAGIC_2}) && (byte_s1 == MAGIC_3);

	assign rel      = pos_q - 16'(off_q);
	assign need     = 17'(off_q) + 17'(HEADER_BYTES)
		+ 17'(13'(RECORD_BYTES) * 13'(byte_s1));
	assign rec_done = idx_q >= IDX_W'(RECORD_BYTES - 1);

	// record buffer as it stands once the current byte is written
	always_comb begin
		for (int k = 0; k < 22; k++) begin
			rview[k] = (idx_q == IDX_W'(k)) ? byte_s1 : rbuf_q[k];
		end
	end

	always_comb begin
		phase_d = phase_q;
		off_d   = off_q;
		left_d  = left_q;
		idx_d   = idx_q;
		time_d  = time_q;
		err_d   = err_q;
		push    = '0;
		unique case (phase_q)
			PH_SCAN: begin
				if (magic_hit) begin
					off_d   = OFF_W'(pos_q - 16'd3);
					phase_d = PH_HEAD;
					time_d  = '0;
				end
			end
			PH_HEAD: begin
				if (rel == 16'(VERSION_REL)) begin
					if (byte_s1 != VERSION_ONE) begin
						err_d   = ST_BAD_VERSION;
						phase_d = PH_DONE;
					end
				end else if (rel == 16'(COUNT_REL)) begin
					left_d = byte_s1;
					if ({1'b0, len_s1} < need) begin
						err_d   = ST_TOO_SHORT;
						phase_d = PH_DONE;
					end
				end else begin
					for (int k = 0; k < TIME_BYTES; k++) begin
						if (rel == 16'(TIME_FIRST + k)) begin
							time_d[8*k +: 8] = byte_s1;
						end
					end
				end
				if (phase_d == PH_HEAD && rel >= 16'(HEADER_BYTES - 1)) begin
					idx_d   = '0;
					phase_d = (left_d != 8'd0) ? PH_REC : PH_DONE;
				end
			end
			PH_REC: begin
				if (rec_done) begin
					push.rec = fire;
					idx_d    = '0;
					left_d   = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_d = PH_DONE;
					end
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			PH_DONE: begin
				// trailing bytes ignored until the end of the packet
			end
			default: begin
				phase_d = PH_SCAN;
			end
		endcase
		push.stat = fire && last_s1;
	end

	always_comb begin
		rec_res              = '0;
		rec_res.item_kind    = KIND_RECORD;
		rec_res.status       = ST_OK;
		rec_res.server_time  = time_q;
		rec_res.entity_id    = {rview[1], rview[0]};
		rec_res.record_flags = rview[2];
		rec_res.team_id      = rview[3];
		rec_res.pos_x_bits   = {rview[7], rview[6], rview[5], rview[4]};
		rec_res.pos_y_bits   = {rview[11], rview[10], rview[9], rview[8]};
		rec_res.pos_z_bits   = {rview[15], rview[14], rview[13], rview[12]};
		rec_res.yaw_bits     = {rview[19], rview[18], rview[17], rview[16]};
		rec_res.damage       = rview[20];
		rec_res.anim_num     = rview[21];

		stat_res             = '0;
		stat_res.item_kind   = KIND_STATUS;
		stat_res.server_time = time_d;
		if (phase_d == PH_DONE) begin
			stat_res.status = err_d;
		end else if (phase_d == PH_SCAN) begin
			stat_res.status = ST_NO_MAGIC;
		end else begin
			stat_res.status = ST_TOO_SHORT;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && phase_q == PH_REC) begin
			rbuf_q[idx_q] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			recent_q <= '0;
			phase_q  <= PH_SCAN;
			off_q    <= '0;
			left_q   <= '0;
			idx_q    <= '0;
			time_q   <= '0;
			err_q    <= ST_OK;
		end else if (fire) begin
			if (last_s1) begin
				// packet over: back to scanning for the next one
				pos_q    <= '0;
				recent_q <= '0;
				phase_q  <= PH_SCAN;
				off_q    <= '0;
				left_q   <= '0;
				idx_q    <= '0;
				time_q   <= '0;
				err_q    <= ST_OK;
			end else begin
				pos_q    <= (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
				recent_q <= {recent_q[15:0], byte_s1};
				phase_q  <= phase_d;
				off_q    <= off_d;
				left_q   <= left_d;
				idx_q    <= idx_d;
				time_q   <= time_d;
				err_q    <= err_d;
			end
		end
	end

	gbpp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rec_res  (rec_res),
		.stat_res (stat_res),
		.room     (room),
		.res_out  (res_out)
	);

endmodule

// ===== hdl/gbpp_checker.sv =====
// Port-level checks for the ghost burst packet parser, bound to the top level.
// Depends on gbpp_pkg.
module gbpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_kind,
	input logic [1:0]  out_status,
	input logic [63:0] out_time
);
	import gbpp_pkg::*;

	// fresh out of reset: byte register free, queue empty
	a_reset_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_ready && !out_valid)
		else $error("not idle after reset");

	// an empty result queue never holds off the byte stream
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result queue");

	a_record_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_RECORD |-> out_status == ST_OK)
		else $error("record result with non-zero status");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_time))
		else $error("stalled result changed");

endmodule

bind ghost_burst_packet_parser gbpp_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (pkt_in.ready),
	.out_valid  (res_out.valid),
	.out_ready  (res_out.ready),
	.out_kind   (res_out.item_kind),
	.out_status (res_out.status),
	.out_time   (res_out.server_time)
);
